// ===== rtl/rtsg_pkg.sv =====
package rtsg_pkg;

  localparam int HOLD_DEPTH = 64;
  localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
  localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);
  localparam int OPEN_LEN   = 7;
  localparam int CLOSE_LEN  = 8;

  // What an accepted transfer does in the datapath.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PASS  = 2'd1,
    OP_THINK = 2'd2,
    OP_UNDEC = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    logic rd_start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic close_hit;
    logic open_done;
    logic flush;
    logic out_free;
    logic drain_last;
  } dp_sts_t;

  // "<think>"
  function automatic logic [7:0] open_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h3C;
      3'd1: c = 8'h74;
      3'd2: c = 8'h68;
      3'd3: c = 8'h69;
      3'd4: c = 8'h6E;
      3'd5: c = 8'h6B;
      3'd6: c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "</think>"
  function automatic logic [7:0] close_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h3C;
      3'd1: c = 8'h2F;
      3'd2: c = 8'h74;
      3'd3: c = 8'h68;
      3'd4: c = 8'h69;
      3'd5: c = 8'h6E;
      3'd6: c = 8'h6B;
      3'd7: c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/reasoning_tag_stream_gate.sv =====
// A passing byte is registered and appears on the output in the cycle after its transfer.
// One byte is taken per cycle while undecided or inside reasoning, and while passing
// unless the output stalls. A piece-end flush stalls the input; S_READ fetches the first
// held byte from the hold RAM, then S_EMIT sends one per cycle while the output is free.
// Reset (synchronous, rst_n low) clears the mode, match state, count and overflow flag;
// the hold RAM is not cleared.
module reasoning_tag_stream_gate (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_piece_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_overflow_seen
);

  rtsg_pkg::dp_cmd_t cmd;
  rtsg_pkg::dp_sts_t sts;

  rtsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rtsg_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte           (in_byte),
    .in_piece_end      (in_piece_end),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_overflow_seen (out_overflow_seen)
  );

endmodule

// ===== rtl/rtsg_dp.sv =====
module rtsg_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  logic               in_piece_end,
  input  logic               out_stall,
  input  rtsg_pkg::dp_cmd_t  cmd,
  output rtsg_pkg::dp_sts_t  sts,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run,
  output logic               out_overflow_seen
);

  logic [2:0]                     close_r;
  logic                           open_ok_r;
  logic [rtsg_pkg::HOLD_CW-1:0]   cnt_r;
  logic                           ovf_r;
  logic [rtsg_pkg::HOLD_AW-1:0]   idx_r;
  logic [7:0]                     rd_data_r;
  logic                           out_valid_r;
  logic [7:0]                     out_byte_r;
  logic                           out_last_r;
  logic                           out_ovf_r;
  logic [7:0]                     mem [rtsg_pkg::HOLD_DEPTH];

  logic [3:0]                     close_nxt;
  logic                           close_hit;
  logic                           store;
  logic                           open_bad;
  logic                           ok_nxt;
  logic [rtsg_pkg::HOLD_CW-1:0]   cnt_inc;
  logic                           out_free;
  logic                           drain_last;
  logic                           rd_en;
  logic [rtsg_pkg::HOLD_AW-1:0]   rd_addr;
  logic                           mem_we;

  // The closing tag has no self-overlap, so a mismatch restarts at zero or one.
  always_comb begin
    if (in_byte == rtsg_pkg::close_char(close_r)) begin
      close_nxt = {1'b0, close_r} + 4'd1;
    end else if (in_byte == rtsg_pkg::close_char(3'd0)) begin
      close_nxt = 4'd1;
    end else begin
      close_nxt = 4'd0;
    end
  end

  assign close_hit  = (close_nxt == 4'(rtsg_pkg::CLOSE_LEN));
  assign store      = (cnt_r < rtsg_pkg::HOLD_CW'(rtsg_pkg::HOLD_DEPTH));
  assign open_bad   = (cnt_r < rtsg_pkg::HOLD_CW'(rtsg_pkg::OPEN_LEN)) &&
                      (in_byte != rtsg_pkg::open_char(cnt_r[2:0]));
  assign ok_nxt     = open_ok_r && !(store && open_bad);
  assign cnt_inc    = store ? cnt_r + rtsg_pkg::HOLD_CW'(1) : cnt_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign drain_last = ({1'b0, idx_r} + rtsg_pkg::HOLD_CW'(1)) == cnt_r;
  assign mem_we     = (cmd.op == rtsg_pkg::OP_UNDEC) && !close_hit && store;

  assign sts.close_hit  = close_hit;
  assign sts.open_done  = ok_nxt && (cnt_inc >= rtsg_pkg::HOLD_CW'(rtsg_pkg::OPEN_LEN));
  assign sts.flush      = in_piece_end && !ok_nxt;
  assign sts.out_free   = out_free;
  assign sts.drain_last = drain_last;

  // While draining, the next address is fetched as the current byte leaves.
  assign rd_en   = cmd.rd_start || cmd.emit;
  assign rd_addr = cmd.rd_start ? '0 : idx_r + rtsg_pkg::HOLD_AW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[rtsg_pkg::HOLD_AW-1:0]] <= in_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_r   <= '0;
      open_ok_r <= 1'b1;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      idx_r     <= '0;
    end else begin
      case (cmd.op)
        rtsg_pkg::OP_THINK, rtsg_pkg::OP_UNDEC: begin
          if (close_hit) begin
            close_r   <= '0;
            cnt_r     <= '0;
            open_ok_r <= 1'b1;
          end else begin
            close_r <= close_nxt[2:0];
            if (cmd.op == rtsg_pkg::OP_UNDEC) begin
              cnt_r     <= cnt_inc;
              open_ok_r <= ok_nxt;
              if (!store) begin
                ovf_r <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
      if (cmd.rd_start) begin
        idx_r <= '0;
      end else if (cmd.emit) begin
        idx_r <= idx_r + rtsg_pkg::HOLD_AW'(1);
        if (drain_last) begin
          cnt_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.op == rtsg_pkg::OP_PASS) || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rtsg_pkg::OP_PASS) begin
      out_byte_r <= in_byte;
      out_last_r <= 1'b1;
      out_ovf_r  <= ovf_r;
    end else if (cmd.emit) begin
      out_byte_r <= rd_data_r;
      out_last_r <= drain_last;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_overflow_seen = out_ovf_r;

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared after being set");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rtsg_pkg::HOLD_CW'(rtsg_pkg::HOLD_DEPTH))
    else $error("hold count beyond store depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_start |-> (cnt_r != '0))
    else $error("drain started with an empty hold store");

endmodule

// ===== rtl/rtsg_ctrl.sv =====
module rtsg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rtsg_pkg::dp_sts_t  sts,
  output logic               in_stall,
  output rtsg_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_UNDEC = 5'b00001,
    S_THINK = 5'b00010,
    S_PASS  = 5'b00100,
    S_READ  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  always_comb begin
    case (state_r)
      S_UNDEC, S_THINK: in_stall = 1'b0;
      S_PASS:           in_stall = !sts.out_free;
      default:          in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd.op       = rtsg_pkg::OP_NONE;
    cmd.rd_start = 1'b0;
    cmd.emit     = 1'b0;
    state_nxt    = state_r;
    case (state_r)
      S_UNDEC: begin
        if (accept) begin
          cmd.op = rtsg_pkg::OP_UNDEC;
          if (sts.close_hit) begin
            state_nxt = S_PASS;
          end else if (sts.open_done) begin
            state_nxt = S_THINK;
          end else if (sts.flush) begin
            state_nxt = S_READ;
          end
        end
      end
      S_THINK: begin
        if (accept) begin
          cmd.op = rtsg_pkg::OP_THINK;
          if (sts.close_hit) begin
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (accept) begin
          cmd.op = rtsg_pkg::OP_PASS;
        end
      end
      S_READ: begin
        cmd.rd_start = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.drain_last) begin
            state_nxt = S_PASS;
          end
        end
      end
      default: begin
        state_nxt = S_UNDEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_UNDEC;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_READ) || (state_r == S_EMIT)) |-> in_stall)
    else $error("input taken during drain");

  a_pass_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS) |=> (state_r == S_PASS))
    else $error("left passing mode");

  a_emit_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && !(cmd.emit && sts.drain_last)) |=> (state_r == S_EMIT))
    else $error("drain ended before the last held byte");

endmodule

// ===== sim/tag_gate_checker.sv =====
module tag_gate_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_piece_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_last_of_run,
  input  logic       out_overflow_seen,
  output int         fail_count,
  output int         pending,
  output int         bytes_in,
  output int         bytes_out
);

  typedef enum logic [1:0] {
    GATE_UNDECIDED = 2'd0,
    GATE_THINKING  = 2'd1,
    GATE_PASSING   = 2'd2
  } gate_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } release_t;

  localparam logic [8*rtsg_pkg::OPEN_LEN-1:0]  OPEN_TAG  = "<think>";
  localparam logic [8*rtsg_pkg::CLOSE_LEN-1:0] CLOSE_TAG = "</think>";

  gate_mode_t mode;
  int         close_len;
  logic       prefix_ok;
  int         held_cnt;
  logic [7:0] held_store [rtsg_pkg::HOLD_DEPTH];
  logic       ovf_flag;
  release_t   release_q [$];
  release_t   want;
  int         fails;
  int         n_in;
  int         n_out;

  initial begin
    fails = 0;
    n_in  = 0;
    n_out = 0;
  end

  // Character idx of a tag stored left to right in a packed vector.
  function automatic logic [7:0] tag_char(input logic [63:0] tag, input int len,
                                          input int idx);
    return tag[8*(len-1-idx) +: 8];
  endfunction

  // Appends one expected released byte at the tail of the queue.
  function automatic void add_release(input release_t r);
    release_q.insert(release_q.size(), r);
  endfunction

  task automatic predict_transfer(input logic [7:0] b, input logic pe);
    int i;
    if (mode == GATE_PASSING) begin
      add_release({b, 1'b1, ovf_flag});
    end else begin
      // The closing tag has no self-overlap, so a mismatch restarts at zero or one.
      if (close_len < rtsg_pkg::CLOSE_LEN &&
          b == tag_char(CLOSE_TAG, rtsg_pkg::CLOSE_LEN, close_len))
        close_len++;
      else
        close_len = (b == tag_char(CLOSE_TAG, rtsg_pkg::CLOSE_LEN, 0)) ? 1 : 0;

      if (close_len >= rtsg_pkg::CLOSE_LEN) begin
        mode      = GATE_PASSING;
        close_len = 0;
        held_cnt  = 0;
        prefix_ok = 1'b1;
      end else if (mode == GATE_UNDECIDED) begin
        if (held_cnt < rtsg_pkg::HOLD_DEPTH) begin
          if (held_cnt < rtsg_pkg::OPEN_LEN &&
              b != tag_char(64'(OPEN_TAG), rtsg_pkg::OPEN_LEN, held_cnt))
            prefix_ok = 1'b0;
          held_store[held_cnt] = b;
          held_cnt++;
        end else begin
          ovf_flag = 1'b1;
        end

        if (prefix_ok && held_cnt >= rtsg_pkg::OPEN_LEN) begin
          mode = GATE_THINKING;
        end else if (pe && !prefix_ok) begin
          for (i = 0; i < held_cnt; i++)
            add_release({held_store[i], i == held_cnt - 1, ovf_flag});
          held_cnt = 0;
          mode     = GATE_PASSING;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode      = GATE_UNDECIDED;
      close_len = 0;
      prefix_ok = 1'b1;
      held_cnt  = 0;
      ovf_flag  = 1'b0;
      release_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (release_q.size() == 0) begin
          fails++;
          $display("%0t: released byte %02h last %0d ovf %0d with nothing expected",
                   $time, out_byte, out_last_of_run, out_overflow_seen);
        end else begin
          want = release_q.pop_front();
          if (want !== {out_byte, out_last_of_run, out_overflow_seen}) begin
            fails++;
            $display("%0t: expected byte %02h last %0d ovf %0d, got byte %02h last %0d ovf %0d",
                     $time, want.data, want.last, want.ovf,
                     out_byte, out_last_of_run, out_overflow_seen);
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_in++;
        predict_transfer(in_byte, in_piece_end);
      end
    end
    pending    <= release_q.size();
    fail_count <= fails;
    bytes_in   <= n_in;
    bytes_out  <= n_out;
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;

  localparam int QUIET_LIMIT = 600;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_piece_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       out_overflow_seen;

  int    fail_count;
  int    pending;
  int    bytes_in;
  int    bytes_out;
  int    quiet_cycles;
  logic  tx_idle_en;
  logic  rx_stall_en;
  string opening;

  reasoning_tag_stream_gate dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_piece_end     (in_piece_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_overflow_seen(out_overflow_seen)
  );

  tag_gate_checker gate_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_piece_end     (in_piece_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_overflow_seen(out_overflow_seen),
    .fail_count       (fail_count),
    .pending          (pending),
    .bytes_in         (bytes_in),
    .bytes_out        (bytes_out)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver back-pressure in random bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid and payload stay up after a transfer; the next call either keeps
  // them up with new data or drops valid for an idle burst.
  task automatic send_byte(input logic [7:0] b, input logic pe);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_piece_end <= pe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic pe_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], pe_last && (i == s.len() - 1));
  endtask

  task automatic drain_releases();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    in_piece_end = 1'b0;
    tx_idle_en   = 1'b1;
    rx_stall_en  = 1'b1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // The gate decides only once per reset, so the seed picks how the stream opens.
    case ($urandom_range(0, 3))
      0: begin
        opening = "reasoning block";
        send_text("<th", 1'b1);        // piece ends on a still-valid prefix
        send_text("ink", 1'b1);
        send_text(">", 1'b0);
        send_text("</thin", 1'b0);
        repeat (5) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_text("</think!", 1'b1);   // closing tag broken at its last character
        send_text("<</think>", 1'b0);
      end
      1: begin
        opening = "hold overflow and flush";
        send_text("<thinX", 1'b0);
        send_text("</thi", 1'b0);
        repeat (56) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        opening = "prefix broken on the last tag character";
        send_text("<think", 1'b0);
        send_byte(8'h78, 1'b1);
      end
      default: begin
        opening = "closing tag inside held text";
        send_text("hi <t", 1'b0);
        send_text("</think>", 1'b1);
      end
    endcase

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    drain_releases();

    for (int seg = 0; seg < 8; seg++) begin
      tx_idle_en  = $urandom_range(0, 3) != 0;
      rx_stall_en = $urandom_range(0, 3) != 0;
      if (seg == 4)
        drain_releases();
      if (seg == 7) begin
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
      end
      for (int k = 0; k < 25; k++) begin
        case ($urandom_range(0, 15))
          0:       send_text("<think>", 1'($urandom_range(0, 1)));
          1:       send_text("</think>", 1'($urandom_range(0, 1)));
          default: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        endcase
      end
    end

    drain_releases();
    repeat (16) @(negedge clk);

    $display("Stream opened with %s; %0d bytes sent, %0d released bytes checked.",
             opening, bytes_in, bytes_out);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rtsg_pkg.sv
rtl/rtsg_dp.sv
rtl/rtsg_ctrl.sv
rtl/reasoning_tag_stream_gate.sv
sim/tag_gate_checker.sv
sim/testbench.sv
